@@ design/cabb_pkg.sv @@
// Shared types, constants and helper functions for the clipped alpha-blend blit.
`default_nettype none

package cabb_pkg;

    // Field widths fixed by the pixel and register formats.
    localparam int DIM_W    = 13;
    localparam int ADDR_W   = 24;
    localparam int PIX_W    = 32;
    localparam int CHAN_W   = 8;
    localparam int CFG_W    = 13;
    localparam int REGIDX_W = 3;
    localparam int PROD_W   = 17;

    // Pixel constants.
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'hFF;
    localparam logic [PROD_W-1:0] ROUND_BIAS = 17'd128;

    // Depth of the queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Configuration register indexes.
    typedef enum logic [REGIDX_W-1:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_SOURCE_WIDTH  = 3'd2,
        REG_SOURCE_HEIGHT = 3'd3,
        REG_TARGET_WIDTH  = 3'd4,
        REG_TARGET_HEIGHT = 3'd5,
        REG_BLEND_SELECT  = 3'd6,
        REG_ALPHA_OFFSET  = 3'd7
    } reg_idx_t;

    typedef enum logic {
        BLEND_ROUNDED  = 1'b0,
        BLEND_STRAIGHT = 1'b1
    } blend_t;

    // What the back part does with a pixel.
    typedef enum logic [1:0] {
        ACT_PASS     = 2'd0,
        ACT_COPY     = 2'd1,
        ACT_ROUND    = 2'd2,
        ACT_STRAIGHT = 2'd3
    } act_t;

    typedef struct packed {
        logic signed [DIM_W-1:0] origin_x;
        logic signed [DIM_W-1:0] origin_y;
        logic [DIM_W-1:0]        source_width;
        logic [DIM_W-1:0]        source_height;
        logic [DIM_W-1:0]        target_width;
        logic [DIM_W-1:0]        target_height;
        blend_t                  blend_select;
        logic [CHAN_W-1:0]       alpha_offset;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] source_pixel;
        logic [PIX_W-1:0] target_pixel;
    } pix_in_t;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] target_address;
        logic [PIX_W-1:0]  blended_pixel;
        logic              image_done;
    } pix_out_t;

    // One classified pixel waiting in the queue.
    typedef struct packed {
        act_t              act;
        logic [ADDR_W-1:0] addr;
        logic              done;
        logic [PIX_W-1:0]  src;
        logic [PIX_W-1:0]  dst;
        logic [CHAN_W-1:0] alpha;
    } q_entry_t;

    // Floor of y / 255, exact for y below 65535.
    function automatic logic [CHAN_W:0] div255(input logic [PROD_W-1:0] y);
        logic [PROD_W-1:0] t;
        t = y + PROD_W'(1) + PROD_W'(y >> 8);
        return t[PROD_W-1:8];
    endfunction

endpackage

`default_nettype wire

@@ design/cabb_front.sv @@
// Front part: raster counters, clipping, address and pixel classification.
`default_nettype none

module cabb_front #(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire cabb_pkg::pix_in_t in_data,
    input  wire cabb_pkg::cfg_t    cfg,
    input  wire logic              q_full,
    output logic                   in_ready,
    output logic                   q_push,
    output cabb_pkg::q_entry_t     q_entry
);
    import cabb_pkg::*;

    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int XW = ((CW > DIM_W) ? CW : DIM_W) + 1;

    // A size of zero acts as one, a size above the limit acts as the limit.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            return DIM_W'(1);
        else if (32'(v) > 32'(MAX_DIMENSION))
            return DIM_W'(MAX_DIMENSION);
        else
            return v;
    endfunction

    logic [CW-1:0]     col_reg, col_next;
    logic [CW-1:0]     row_reg, row_next;
    logic [DIM_W-1:0]  sw, sh, tw, th;
    logic [XW:0]       dx, dy;
    logic              in_bounds;
    logic              last_col, last_row;
    logic              accept;
    logic [CHAN_W-1:0] sa;
    logic [CHAN_W:0]   sa_sum;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;

    assign sw = clamp_dim(cfg.source_width);
    assign sh = clamp_dim(cfg.source_height);
    assign tw = clamp_dim(cfg.target_width);
    assign th = clamp_dim(cfg.target_height);

    // Destination coordinates of the current source pixel.
    assign dx = {{(XW + 1 - DIM_W){cfg.origin_x[DIM_W-1]}}, cfg.origin_x}
              + {{(XW + 1 - CW){1'b0}}, col_reg};
    assign dy = {{(XW + 1 - DIM_W){cfg.origin_y[DIM_W-1]}}, cfg.origin_y}
              + {{(XW + 1 - CW){1'b0}}, row_reg};

    assign in_bounds = !dx[XW] && !dy[XW]
                    && (dx[XW-1:0] < XW'(tw)) && (dy[XW-1:0] < XW'(th));

    assign last_col = (XW'(col_reg) + XW'(1)) >= XW'(sw);
    assign last_row = (XW'(row_reg) + XW'(1)) >= XW'(sh);

    // Counter advance.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + CW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign sa     = in_data.source_pixel[PIX_W-1 -: CHAN_W];
    assign sa_sum = {1'b0, sa} + {1'b0, cfg.alpha_offset};

    // Classify the beat and build its queue entry.
    always_comb
    begin
        q_entry.src   = in_data.source_pixel;
        q_entry.dst   = in_data.target_pixel;
        q_entry.done  = last_col && last_row;
        q_entry.alpha = sa;
        q_entry.addr  = '0;
        q_entry.act   = ACT_PASS;
        if (in_bounds)
        begin
            q_entry.addr = ADDR_W'(dy[DIM_W-1:0]) * ADDR_W'(tw)
                         + ADDR_W'(dx[DIM_W-1:0]);
        end
        priority if (!in_bounds)
        begin
            q_entry.act = ACT_PASS;
        end
        else if (cfg.blend_select == BLEND_ROUNDED)
        begin
            priority if (sa == CHAN_MAX)
                q_entry.act = ACT_COPY;
            else if (sa == '0)
                q_entry.act = ACT_PASS;
            else
                q_entry.act = ACT_ROUND;
        end
        else
        begin
            q_entry.alpha = sa_sum[CHAN_W-1:0];
            priority if (sa_sum >= {1'b0, CHAN_MAX})
                q_entry.act = ACT_COPY;
            else if (sa_sum == '0)
                q_entry.act = ACT_PASS;
            else
                q_entry.act = ACT_STRAIGHT;
        end
    end

endmodule

`default_nettype wire

@@ design/cabb_fifo.sv @@
// Short queue of classified pixels between the front and back parts.
`default_nettype none

module cabb_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire cabb_pkg::q_entry_t push_data,
    input  wire logic               pop,
    output logic                    full,
    output logic                    valid,
    output cabb_pkg::q_entry_t      pop_data
);
    import cabb_pkg::*;

    q_entry_t       entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   cnt_reg, cnt_next;

    assign full     = (cnt_reg == (QAW + 1)'(QDEPTH));
    assign valid    = (cnt_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (QAW + 1)'(push) - (QAW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

@@ design/cabb_back.sv @@
// Back part: two-stage blend pipeline with the output register.
`default_nettype none

module cabb_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire cabb_pkg::q_entry_t q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cabb_pkg::pix_out_t      out_data
);
    import cabb_pkg::*;

    typedef struct packed {
        q_entry_t              e;
        logic [CHAN_W-1:0]     da;
        logic [3*CHAN_W-1:0]   mix;
    } s1_t;

    s1_t      s1_reg, s1_next;
    logic     s1_valid_reg;
    pix_out_t out_reg, out_next;
    logic     out_valid_reg;
    logic     en;

    // The whole pipeline moves unless a finished beat is held at the output.
    assign en        = !out_valid_reg || out_ready;
    assign q_pop     = en && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Stage one: destination alpha for rounded mode, channel mix for straight mode.
    always_comb
    begin
        logic [CHAN_W-1:0] a_inv;
        logic [PROD_W-1:0] da_prod;
        logic [PROD_W-1:0] mix_prod;
        logic [CHAN_W:0]   q;
        a_inv     = CHAN_MAX - q_data.alpha;
        s1_next.e = q_data;
        da_prod   = PROD_W'(q_data.dst[PIX_W-1 -: CHAN_W]) * PROD_W'(a_inv) + ROUND_BIAS;
        q         = div255(da_prod);
        s1_next.da = q[CHAN_W-1:0];
        s1_next.mix = '0;
        for (int i = 0; i < 3; i++)
        begin
            mix_prod = PROD_W'(q_data.src[CHAN_W*i +: CHAN_W]) * PROD_W'(q_data.alpha)
                     + PROD_W'(q_data.dst[CHAN_W*i +: CHAN_W]) * PROD_W'(a_inv);
            q = div255(mix_prod);
            s1_next.mix[CHAN_W*i +: CHAN_W] = q[CHAN_W-1:0];
        end
    end

    // Stage two: rounded channel sums with saturation and result selection.
    always_comb
    begin
        logic [CHAN_W:0]     t1;
        logic [CHAN_W:0]     t2;
        logic [CHAN_W:0]     sum;
        logic [3*CHAN_W-1:0] rgb;
        rgb = '0;
        for (int i = 0; i < 3; i++)
        begin
            t1  = div255(PROD_W'(s1_reg.e.dst[CHAN_W*i +: CHAN_W]) * PROD_W'(s1_reg.da)
                         + ROUND_BIAS);
            t2  = div255(PROD_W'(s1_reg.e.src[CHAN_W*i +: CHAN_W]) * PROD_W'(s1_reg.e.alpha)
                         + ROUND_BIAS);
            sum = {1'b0, t1[CHAN_W-1:0]} + {1'b0, t2[CHAN_W-1:0]};
            rgb[CHAN_W*i +: CHAN_W] = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
        end
        out_next.target_address = s1_reg.e.addr;
        out_next.image_done     = s1_reg.e.done;
        unique case (s1_reg.e.act)
            ACT_PASS:
            begin
                out_next.write_enable  = 1'b0;
                out_next.blended_pixel = s1_reg.e.dst;
            end
            ACT_COPY:
            begin
                out_next.write_enable  = 1'b1;
                out_next.blended_pixel = s1_reg.e.src;
            end
            ACT_ROUND:
            begin
                out_next.write_enable  = 1'b1;
                out_next.blended_pixel = {s1_reg.da, rgb};
            end
            ACT_STRAIGHT:
            begin
                out_next.write_enable  = 1'b1;
                out_next.blended_pixel = {{CHAN_W{1'b0}}, s1_reg.mix};
            end
            default:
            begin
                out_next.write_enable  = 1'b0;
                out_next.blended_pixel = s1_reg.e.dst;
            end
        endcase
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= q_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= s1_next;
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

@@ design/clipped_alpha_blend_blit.sv @@
// Top level of the clipped alpha-blend blit: configuration registers and the pipeline parts.
//
//   channel   direction   handshake              payload
//   in        input       in_valid / in_ready    in_data  (source and target pixel)
//   out       output      out_valid / out_ready  out_data (enable, address, pixel, done)
//   cfg       input       cfg_write              cfg_index, cfg_data
//
// One pixel per cycle is accepted and delivered while the output is not stalled; a beat
// passes three registers: the queue entry, the stage-one register and the output register.
// Reset clears the counters, the queue and the pipeline valid flags, and sets
// the registers to origin zero, all sizes one, rounded blending, offset zero.
// A stalled output holds the pipeline; the four-entry queue keeps taking input
// until it fills, and then in_ready drops.
`default_nettype none

module clipped_alpha_blend_blit #(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire cabb_pkg::pix_in_t                 in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output cabb_pkg::pix_out_t                     out_data,
    input  wire logic                              cfg_write,
    input  wire logic [cabb_pkg::REGIDX_W-1:0]     cfg_index,
    input  wire logic [cabb_pkg::CFG_W-1:0]        cfg_data
);
    import cabb_pkg::*;

    cfg_t     cfg_reg;
    logic     q_push;
    q_entry_t q_entry;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    q_entry_t q_data;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.source_width  <= DIM_W'(1);
            cfg_reg.source_height <= DIM_W'(1);
            cfg_reg.target_width  <= DIM_W'(1);
            cfg_reg.target_height <= DIM_W'(1);
            cfg_reg.blend_select  <= BLEND_ROUNDED;
            cfg_reg.alpha_offset  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_ORIGIN_X:      cfg_reg.origin_x      <= cfg_data[DIM_W-1:0];
                REG_ORIGIN_Y:      cfg_reg.origin_y      <= cfg_data[DIM_W-1:0];
                REG_SOURCE_WIDTH:  cfg_reg.source_width  <= cfg_data[DIM_W-1:0];
                REG_SOURCE_HEIGHT: cfg_reg.source_height <= cfg_data[DIM_W-1:0];
                REG_TARGET_WIDTH:  cfg_reg.target_width  <= cfg_data[DIM_W-1:0];
                REG_TARGET_HEIGHT: cfg_reg.target_height <= cfg_data[DIM_W-1:0];
                REG_BLEND_SELECT:  cfg_reg.blend_select  <= blend_t'(cfg_data[0]);
                REG_ALPHA_OFFSET:  cfg_reg.alpha_offset  <= cfg_data[CHAN_W-1:0];
                default:           cfg_reg.alpha_offset  <= cfg_reg.alpha_offset;
            endcase
        end
    end

    cabb_front #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .in_ready (in_ready),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    cabb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_entry),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    cabb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ verif/cabb_checker.sv @@
// Checker for the clipped alpha-blend blit: tracks registers, predicts each beat, compares.
`timescale 1ns / 100ps

module blit_checker #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  cabb_pkg::pix_in_t             in_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  cabb_pkg::pix_out_t            out_data,
    input  logic                          cfg_write,
    input  logic [cabb_pkg::REGIDX_W-1:0] cfg_index,
    input  logic [cabb_pkg::CFG_W-1:0]    cfg_data,
    output int                            mismatch_count,
    output int                            outstanding
);
    import cabb_pkg::*;

    localparam int OPAQUE     = 255;
    localparam int HALF_STEP  = 128;

    // Shadow copy of the register file and the raster position.
    cfg_t        setup;
    logic [11:0] raster_col;
    logic [11:0] raster_row;

    // Predicted results, oldest first.
    pix_out_t    expected_writes[$];
    int          results_seen;

    // Zero reads as one, anything past the maximum reads as the maximum.
    function automatic int fit_dimension(input logic [DIM_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > MAX_DIMENSION)
            return MAX_DIMENSION;
        return int'(v);
    endfunction

    // Predicts the result of one pixel beat and steps the raster position.
    function automatic pix_out_t blit_pixel(input pix_in_t px);
        pix_out_t   res;
        logic [31:0] mix;
        int sw, sh, tw, th, dx, dy, sa, da, c;
        sw = fit_dimension(setup.source_width);
        sh = fit_dimension(setup.source_height);
        tw = fit_dimension(setup.target_width);
        th = fit_dimension(setup.target_height);
        dx = int'($signed(setup.origin_x)) + int'(raster_col);
        dy = int'($signed(setup.origin_y)) + int'(raster_row);
        res.write_enable   = 1'b0;
        res.target_address = '0;
        res.blended_pixel  = px.target_pixel;
        res.image_done     = 1'b0;

        if (dx >= 0 && dy >= 0 && dx < tw && dy < th)
        begin
            res.target_address = ADDR_W'(dy * tw + dx);
            sa = int'(px.source_pixel[31:24]);
            if (setup.blend_select == BLEND_STRAIGHT)
                sa = sa + int'(setup.alpha_offset);
            if (sa >= OPAQUE)
            begin
                res.write_enable  = 1'b1;
                res.blended_pixel = px.source_pixel;
            end
            else if (sa != 0)
            begin
                res.write_enable = 1'b1;
                mix = '0;
                if (setup.blend_select == BLEND_ROUNDED)
                begin
                    // Destination alpha is scaled down, then both terms round on their own.
                    da = (int'(px.target_pixel[31:24]) * (OPAQUE - sa) + HALF_STEP) / OPAQUE;
                    mix[31:24] = da[7:0];
                    for (int k = 0; k < 3; k++)
                    begin
                        c = (int'(px.target_pixel[8*k +: 8]) * da + HALF_STEP) / OPAQUE
                          + (int'(px.source_pixel[8*k +: 8]) * sa + HALF_STEP) / OPAQUE;
                        if (c > OPAQUE)
                            c = OPAQUE;
                        mix[8*k +: 8] = c[7:0];
                    end
                end
                else
                begin
                    // Straight blend truncates and leaves the alpha byte clear.
                    for (int k = 0; k < 3; k++)
                    begin
                        c = (int'(px.source_pixel[8*k +: 8]) * sa
                          + int'(px.target_pixel[8*k +: 8]) * (OPAQUE - sa)) / OPAQUE;
                        if (c > OPAQUE)
                            c = OPAQUE;
                        mix[8*k +: 8] = c[7:0];
                    end
                end
                res.blended_pixel = mix;
            end
        end

        // A counter at or past the last column or row closes it out.
        if (int'(raster_col) + 1 >= sw)
        begin
            raster_col = '0;
            if (int'(raster_row) + 1 >= sh)
            begin
                raster_row     = '0;
                res.image_done = 1'b1;
            end
            else
            begin
                raster_row = raster_row + 12'd1;
            end
        end
        else
        begin
            raster_col = raster_col + 12'd1;
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        $display("%0t ns: result beat %0d, %s: got 0x%0h, expected 0x%0h",
                 $time, results_seen, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pix_out_t want;
        if (!rst_n)
        begin
            setup <= '{origin_x: '0, origin_y: '0, source_width: 13'd1,
                       source_height: 13'd1, target_width: 13'd1, target_height: 13'd1,
                       blend_select: BLEND_ROUNDED, alpha_offset: '0};
            raster_col     <= '0;
            raster_row     <= '0;
            expected_writes.delete();
            results_seen   <= 0;
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            // Output beat: compare against the oldest prediction.
            if (out_valid && out_ready)
            begin
                if (expected_writes.size() == 0)
                begin
                    flag_mismatch("result with no pixel pending",
                                  32'(out_data.target_address), 32'd0);
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (out_data.write_enable !== want.write_enable)
                        flag_mismatch("write_enable", 32'(out_data.write_enable),
                                      32'(want.write_enable));
                    if (out_data.target_address !== want.target_address)
                        flag_mismatch("target_address", 32'(out_data.target_address),
                                      32'(want.target_address));
                    if (out_data.blended_pixel !== want.blended_pixel)
                        flag_mismatch("blended_pixel", out_data.blended_pixel,
                                      want.blended_pixel);
                    if (out_data.image_done !== want.image_done)
                        flag_mismatch("image_done", 32'(out_data.image_done),
                                      32'(want.image_done));
                end
                results_seen++;
            end

            // Input beat: predict with the registers as they stand.
            if (in_valid && in_ready)
                expected_writes.push_back(blit_pixel(in_data));

            // Register writes take effect for later pixels.
            if (cfg_write)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_ORIGIN_X:      setup.origin_x      = cfg_data;
                    REG_ORIGIN_Y:      setup.origin_y      = cfg_data;
                    REG_SOURCE_WIDTH:  setup.source_width  = cfg_data;
                    REG_SOURCE_HEIGHT: setup.source_height = cfg_data;
                    REG_TARGET_WIDTH:  setup.target_width  = cfg_data;
                    REG_TARGET_HEIGHT: setup.target_height = cfg_data;
                    REG_BLEND_SELECT:  setup.blend_select  = blend_t'(cfg_data[0]);
                    REG_ALPHA_OFFSET:  setup.alpha_offset  = cfg_data[CHAN_W-1:0];
                    default: ;
                endcase
            end

            outstanding <= expected_writes.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
// Top of the testbench for the clipped alpha-blend blit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import cabb_pkg::*;

    localparam int RANDOM_PIXELS = 410;
    localparam int LONG_HOLD     = 250;
    localparam int TAIL_CYCLES   = 16;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    pix_in_t             in_data;
    logic                out_valid;
    logic                out_ready;
    pix_out_t            out_data;
    logic                cfg_write;
    logic [REGIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    int                  mismatch_count;
    int                  outstanding;

    // Register values the stimulus believes are loaded.
    cfg_t blit_plan;
    bit   hold_request;
    bit   feed_rush;
    bit   feed_calm;
    int   feed_calm_left;

    clipped_alpha_blend_blit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    blit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Offers one pixel beat after a drawn gap and waits until it is taken.
    task automatic feed_pixel(input logic [31:0] src, input logic [31:0] dst);
        int gap;
        if (feed_calm_left == 0)
        begin
            feed_calm      = ($urandom_range(0, 2) == 0);
            feed_calm_left = $urandom_range(16, 64);
        end
        feed_calm_left--;
        gap = (feed_calm || feed_rush) ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{source_pixel: src, target_pixel: dst};
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // Stops offering pixels and waits until every predicted result has come out.
    task automatic settle_blit();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Writes the registers selected by mask, one per cycle, in index order.
    task automatic program_blit(input cfg_t setup, input logic [7:0] mask);
        reg_idx_t idx;
        for (int i = 0; i < 8; i++)
        begin
            idx = reg_idx_t'(i);
            if (mask[i])
            begin
                cfg_write <= 1'b1;
                cfg_index <= idx;
                case (idx)
                    REG_ORIGIN_X:      cfg_data <= setup.origin_x;
                    REG_ORIGIN_Y:      cfg_data <= setup.origin_y;
                    REG_SOURCE_WIDTH:  cfg_data <= setup.source_width;
                    REG_SOURCE_HEIGHT: cfg_data <= setup.source_height;
                    REG_TARGET_WIDTH:  cfg_data <= setup.target_width;
                    REG_TARGET_HEIGHT: cfg_data <= setup.target_height;
                    REG_BLEND_SELECT:  cfg_data <= CFG_W'(setup.blend_select);
                    REG_ALPHA_OFFSET:  cfg_data <= CFG_W'(setup.alpha_offset);
                    default: ;
                endcase
                @(posedge clk);
            end
        end
        cfg_write <= 1'b0;
    endtask

    // Origins sit near zero mostly, with the extremes and the full range now and then.
    function automatic logic [DIM_W-1:0] pick_origin();
        case ($urandom_range(0, 11))
            0:       return DIM_W'(-4096);
            1:       return DIM_W'(4095);
            2:       return DIM_W'($urandom_range(0, 8191));
            default: return DIM_W'(int'($urandom_range(0, 24)) - 12);
        endcase
    endfunction

    // Sizes are small mostly; zero, the maximum and oversize values show up too.
    function automatic logic [DIM_W-1:0] pick_size();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return DIM_W'(4096);
            2:       return DIM_W'($urandom_range(4097, 8191));
            3:       return DIM_W'($urandom_range(9, 4095));
            default: return DIM_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Result side: random stalls, calm stretches, and one long hold-off on request.
    initial
    begin : result_sink
        int  stall;
        int  calm_left;
        bit  calm;
        out_ready = 1'b0;
        calm_left = 0;
        calm      = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (calm_left == 0)
            begin
                calm      = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(16, 64);
            end
            calm_left--;
            stall = calm ? 0 : $urandom_range(0, 17);
            if (hold_request)
            begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int          pixels_sent;
        int          phase;
        int          count;
        logic [31:0] src;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        hold_request   = 1'b0;
        feed_rush      = 1'b0;
        feed_calm      = 1'b0;
        feed_calm_left = 0;
        blit_plan = '{origin_x: '0, origin_y: '0, source_width: 13'd1,
                      source_height: 13'd1, target_width: 13'd1, target_height: 13'd1,
                      blend_select: BLEND_ROUNDED, alpha_offset: '0};
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: a 1x1 image at the origin with rounded blending.
        feed_pixel(32'h00123456, 32'hFFFFFFFF);
        feed_pixel(32'hFFFFFFFF, 32'h00000000);
        feed_pixel(32'h80FF00FF, 32'hC000FF00);

        // Straight blending around the transparent and opaque ends.
        settle_blit();
        blit_plan.blend_select = BLEND_STRAIGHT;
        program_blit(blit_plan, 8'd1 << REG_BLEND_SELECT);
        feed_pixel(32'h00ABCDEF, 32'h12345678);
        feed_pixel(32'hFE00FF80, 32'hFFFF00FF);
        feed_pixel(32'hFF0F1E2D, 32'h00000000);

        // A full offset turns even zero alpha into a copy.
        settle_blit();
        blit_plan.alpha_offset = 8'd255;
        program_blit(blit_plan, 8'd1 << REG_ALPHA_OFFSET);
        feed_pixel(32'h00FFFFFF, 32'h00000000);
        feed_pixel(32'hFF000000, 32'hFFFFFFFF);

        // A small offset lifts zero alpha into a real blend.
        settle_blit();
        blit_plan.alpha_offset = 8'd10;
        program_blit(blit_plan, 8'd1 << REG_ALPHA_OFFSET);
        feed_pixel(32'h00FFFFFF, 32'h00000000);

        // Negative origin: a 3x3 source over a 2x2 target clips its top row and left column.
        settle_blit();
        blit_plan = '{origin_x: DIM_W'(-1), origin_y: DIM_W'(-1), source_width: 13'd3,
                      source_height: 13'd3, target_width: 13'd2, target_height: 13'd2,
                      blend_select: BLEND_ROUNDED, alpha_offset: '0};
        program_blit(blit_plan, 8'hFF);
        repeat (9) feed_pixel({8'hFF, 24'($urandom)}, $urandom);

        // Far corner: the last address of a maximal target, then one column past it.
        settle_blit();
        blit_plan = '{origin_x: DIM_W'(4095), origin_y: DIM_W'(4095), source_width: 13'd2,
                      source_height: 13'd0, target_width: 13'd8191, target_height: 13'd4096,
                      blend_select: BLEND_ROUNDED, alpha_offset: '0};
        program_blit(blit_plan, 8'hFF);
        feed_pixel(32'h7F80FF01, 32'hFF00FF00);
        feed_pixel(32'h7F80FF01, 32'hFF00FF00);

        // Shrinking the source mid-image ends the row, then the image, early.
        settle_blit();
        blit_plan = '{origin_x: '0, origin_y: '0, source_width: 13'd5,
                      source_height: 13'd3, target_width: 13'd8, target_height: 13'd8,
                      blend_select: BLEND_ROUNDED, alpha_offset: '0};
        program_blit(blit_plan, 8'hFF);
        repeat (3) feed_pixel($urandom, $urandom);
        settle_blit();
        blit_plan.source_width = 13'd2;
        program_blit(blit_plan, 8'd1 << REG_SOURCE_WIDTH);
        feed_pixel($urandom, $urandom);
        settle_blit();
        blit_plan.source_height = 13'd1;
        program_blit(blit_plan, 8'd1 << REG_SOURCE_HEIGHT);
        repeat (2) feed_pixel($urandom, $urandom);

        // Random phases: new placement and blend settings, then a run of pixels.
        pixels_sent = 0;
        phase       = 0;
        while (pixels_sent < RANDOM_PIXELS)
        begin
            settle_blit();
            blit_plan.origin_x      = pick_origin();
            blit_plan.origin_y      = pick_origin();
            blit_plan.source_width  = pick_size();
            blit_plan.source_height = pick_size();
            blit_plan.target_width  = pick_size();
            blit_plan.target_height = pick_size();
            blit_plan.blend_select  = blend_t'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       blit_plan.alpha_offset = 8'd0;
                1:       blit_plan.alpha_offset = 8'd255;
                default: blit_plan.alpha_offset = 8'($urandom_range(0, 255));
            endcase
            // Now and then only some registers change, so counters carry over.
            program_blit(blit_plan, ($urandom_range(0, 3) == 0) ?
                                    8'($urandom_range(1, 255)) : 8'hFF);
            count = $urandom_range(8, 40);
            if (phase == 2)
            begin
                // The sink holds off while pixels keep coming, so the input backs up.
                hold_request = 1'b1;
                feed_rush    = 1'b1;
                count        = 48;
            end
            repeat (count)
            begin
                src = $urandom;
                case ($urandom_range(0, 7))
                    0:       src[31:24] = 8'h00;
                    1:       src[31:24] = 8'hFF;
                    2:       src[31:24] = 8'h01;
                    3:       src[31:24] = 8'hFE;
                    // These two land on and just under opaque once the offset is added.
                    4:       src[31:24] = 8'hFF - blit_plan.alpha_offset;
                    5:       src[31:24] = 8'hFE - blit_plan.alpha_offset;
                    default: ;
                endcase
                feed_pixel(src, $urandom);
                pixels_sent++;
            end
            feed_rush = 1'b0;
            phase++;
        end

        settle_blit();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
